// ===== rtl/core/snc_pkg.sv =====
package snc_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 24;

  localparam int unsigned TOL_W   = 25;
  localparam int unsigned LIMIT_W = 6;
  localparam int unsigned ITER_W  = 7;
  localparam int unsigned CFG_W   = 32;

  localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(2);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

  typedef enum logic {
    CFG_TOLERANCE = 1'b0,
    CFG_ITER_LIMIT = 1'b1
  } snc_cfg_e;

  typedef enum logic [1:0] {
    STAT_CONVERGED = 2'd0,
    STAT_LIMIT     = 2'd1,
    STAT_ZERO_DEN  = 2'd2,
    STAT_SATURATED = 2'd3
  } snc_status_e;

  typedef struct packed {
    logic               op;
    logic signed [31:0] k_level;
    logic signed [31:0] first_guess;
    logic signed [31:0] second_guess;
  } snc_in_t;

  typedef struct packed {
    logic signed [31:0]  root;
    logic [ITER_W-1:0]   iterations;
    logic [1:0]          status;
  } snc_out_t;

  typedef struct packed {
    logic done;
    logic sat;
  } snc_md_rsp_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV,
    U_FIN
  } snc_ust_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DEN_A,
    ST_DEN_B,
    ST_K_SQ,
    ST_K0_SQ,
    ST_HILL_DEN,
    ST_HILL,
    ST_K_BASE,
    ST_K_DIV,
    ST_K_RATE,
    ST_Q,
    ST_Q2,
    ST_Q4,
    ST_Q5,
    ST_S_DEN,
    ST_S_HILL,
    ST_S_DIV,
    ST_S_RATE,
    ST_DIFF,
    ST_SLOPE,
    ST_STEP,
    ST_NEXT
  } snc_state_e;

  // round(num/1000 * 2^frac)
  function automatic logic [63:0] thousandths(input int unsigned num, input int unsigned frac);
    logic [63:0] scaled;
    scaled = (64'(num) << frac) + 64'd500;
    return scaled / 64'd1000;
  endfunction

endpackage

// ===== rtl/core/secant_nullcline_solver.sv =====
// Every multiply/divide runs on the shared unit.
// A rate evaluation takes 4 (K rate) or 6 (S rate) unit operations plus a few adds;
// an item takes about (2 + n) rate evaluations and n secant steps, n = updates.
// One item at a time.
// Reset: asynchronous, active low; tolerance 2, iteration limit 10, no memory to clear.
// The result strobe lasts one cycle and cannot be stalled.
module secant_nullcline_solver #(
  parameter int unsigned VALUE_WIDTH = snc_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = snc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  snc_pkg::snc_in_t             req_i,
  output logic                         result_valid_o,
  output snc_pkg::snc_out_t            result_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [snc_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned CMPW = (W > snc_pkg::TOL_W) ? W : snc_pkg::TOL_W;
  localparam logic signed [W-1:0] VMAX = signed'(W'((W+1)'((W+1)'(1) << (W - 1)) - (W+1)'(1)));
  localparam logic signed [W-1:0] VMIN = -VMAX - W'(1);
  localparam logic signed [63:0] VMAX64 = 64'(VMAX);
  localparam logic signed [63:0] VMIN64 = 64'(VMIN);
  localparam logic signed [W-1:0] C_ONE = signed'(W'(64'(1) << FRAC_BITS));
  localparam logic signed [W-1:0] C_AK  = signed'(W'(snc_pkg::thousandths(4, FRAC_BITS)));
  localparam logic signed [W-1:0] C_BK  = signed'(W'(snc_pkg::thousandths(70, FRAC_BITS)));
  localparam logic signed [W-1:0] C_BS  = signed'(W'(snc_pkg::thousandths(820, FRAC_BITS)));
  localparam logic signed [W-1:0] C_K0  = signed'(W'(snc_pkg::thousandths(200, FRAC_BITS)));
  localparam logic signed [W-1:0] C_K1  = signed'(W'(snc_pkg::thousandths(222, FRAC_BITS)));

  snc_pkg::snc_state_e state_q, state_d;

  logic [snc_pkg::TOL_W-1:0]   tol_q, tol_d;
  logic [snc_pkg::LIMIT_W-1:0] limit_q, limit_d;
  logic [snc_pkg::ITER_W-1:0]  cnt_q, cnt_d;
  logic signed [W-1:0] k_q, k_d, ng_q, ng_d, og_q, og_d, nr_q, nr_d, or_q, or_d;
  logic signed [W-1:0] t0_q, t0_d, t1_q, t1_d, t2_q, t2_d, den_q, den_d, d_q, d_d;
  logic op_q, op_d, sat_q, sat_d, init_q, init_d, old_q, old_d, mwait_q, mwait_d;
  logic out_valid_q, out_valid_d;
  snc_pkg::snc_out_t out_q, out_d;

  // shared adder
  logic signed [W-1:0] add_a, add_b, add_res;
  logic                add_sub, add_en, add_sat;
  logic signed [W:0]   add_sum;

  // shared multiply/divide unit
  logic signed [W-1:0] md_a, md_b, md_c, md_res;
  logic                md_state, md_start;
  snc_pkg::snc_md_rsp_t md_rsp;

  logic signed [W-1:0] s_val, fin_val, dmag;
  logic                fin, fin_sat_in;
  logic [1:0]          fin_status;
  logic signed [63:0]  root_wide;
  logic                root_hi, root_lo;
  logic signed [W-1:0] kin, g1in, g2in;
  logic                kin_sat, g1_sat, g2_sat;
  logic                converged, slope_zero, over_limit;
  logic [snc_pkg::ITER_W-1:0] cnt_inc;

  function automatic logic [W:0] clamp_in(input logic signed [31:0] x);
    logic signed [63:0] xw;
    xw = 64'(x);
    if (xw > VMAX64) return {1'b1, VMAX};
    if (xw < VMIN64) return {1'b1, VMIN};
    return {1'b0, W'(xw)};
  endfunction

  assign {kin_sat, kin}   = clamp_in(req_i.k_level);
  assign {g1_sat, g1in}   = clamp_in(req_i.first_guess);
  assign {g2_sat, g2in}   = clamp_in(req_i.second_guess);

  assign add_sum = add_sub ? ((W+1)'(add_a) - (W+1)'(add_b)) : ((W+1)'(add_a) + (W+1)'(add_b));
  assign add_sat = add_en && (add_sum[W] != add_sum[W-1]);
  assign add_res = (add_sum[W] != add_sum[W-1]) ? (add_sum[W] ? VMIN : VMAX) : add_sum[W-1:0];

  assign s_val      = old_q ? og_q : ng_q;
  assign dmag       = add_res[W-1] ? -add_res : add_res;
  assign converged  = CMPW'(unsigned'(dmag)) < CMPW'(tol_q);
  assign slope_zero = add_res == '0;
  assign cnt_inc    = cnt_q + snc_pkg::ITER_W'(1);
  assign over_limit = cnt_inc > snc_pkg::ITER_W'(limit_q);
  assign md_start   = md_state && !mwait_q;

  snc_muldiv #(
    .VALUE_WIDTH(W)
  ) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(md_start),
    .a_i    (md_a),
    .b_i    (md_b),
    .c_i    (md_c),
    .res_o  (md_res),
    .rsp_o  (md_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      snc_pkg::ST_IDLE:     if (start) state_d = snc_pkg::ST_DEN_A;
      snc_pkg::ST_DEN_A:    state_d = snc_pkg::ST_DEN_B;
      snc_pkg::ST_DEN_B:    state_d = op_q ? snc_pkg::ST_Q : snc_pkg::ST_K_SQ;
      snc_pkg::ST_K_SQ:     if (md_rsp.done) state_d = snc_pkg::ST_K0_SQ;
      snc_pkg::ST_K0_SQ:    if (md_rsp.done) state_d = snc_pkg::ST_HILL_DEN;
      snc_pkg::ST_HILL_DEN: state_d = snc_pkg::ST_HILL;
      snc_pkg::ST_HILL:     if (md_rsp.done) state_d = snc_pkg::ST_K_BASE;
      snc_pkg::ST_K_BASE:   state_d = snc_pkg::ST_K_DIV;
      snc_pkg::ST_K_DIV:    if (md_rsp.done) state_d = snc_pkg::ST_K_RATE;
      snc_pkg::ST_Q:        if (md_rsp.done) state_d = snc_pkg::ST_Q2;
      snc_pkg::ST_Q2:       if (md_rsp.done) state_d = snc_pkg::ST_Q4;
      snc_pkg::ST_Q4:       if (md_rsp.done) state_d = snc_pkg::ST_Q5;
      snc_pkg::ST_Q5:       if (md_rsp.done) state_d = snc_pkg::ST_S_DEN;
      snc_pkg::ST_S_DEN:    state_d = snc_pkg::ST_S_HILL;
      snc_pkg::ST_S_HILL:   if (md_rsp.done) state_d = snc_pkg::ST_S_DIV;
      snc_pkg::ST_S_DIV:    if (md_rsp.done) state_d = snc_pkg::ST_S_RATE;
      snc_pkg::ST_K_RATE,
      snc_pkg::ST_S_RATE:   state_d = (init_q && !old_q) ? snc_pkg::ST_DEN_A : snc_pkg::ST_DIFF;
      snc_pkg::ST_DIFF:     state_d = converged ? snc_pkg::ST_IDLE : snc_pkg::ST_SLOPE;
      snc_pkg::ST_SLOPE:    state_d = slope_zero ? snc_pkg::ST_IDLE : snc_pkg::ST_STEP;
      snc_pkg::ST_STEP:     if (md_rsp.done) state_d = snc_pkg::ST_NEXT;
      snc_pkg::ST_NEXT:     state_d = over_limit ? snc_pkg::ST_IDLE : snc_pkg::ST_DEN_A;
      default:              state_d = snc_pkg::ST_IDLE;
    endcase
  end

  // operand selection
  always_comb begin
    add_a    = C_ONE;
    add_b    = k_q;
    add_sub  = 1'b0;
    add_en   = 1'b0;
    md_a     = k_q;
    md_b     = k_q;
    md_c     = C_ONE;
    md_state = 1'b0;
    unique case (state_q)
      snc_pkg::ST_DEN_A:    begin add_a = C_ONE; add_b = k_q; add_en = 1'b1; end
      snc_pkg::ST_DEN_B:    begin add_a = t0_q; add_b = s_val; add_en = 1'b1; end
      snc_pkg::ST_HILL_DEN: begin add_a = t2_q; add_b = t1_q; add_en = 1'b1; end
      snc_pkg::ST_K_BASE:   begin add_a = C_AK; add_b = t2_q; add_en = 1'b1; end
      snc_pkg::ST_S_DEN:    begin add_a = C_ONE; add_b = t2_q; add_en = 1'b1; end
      snc_pkg::ST_K_RATE,
      snc_pkg::ST_S_RATE: begin
        add_a = t0_q; add_b = t1_q; add_sub = 1'b1; add_en = 1'b1;
      end
      snc_pkg::ST_DIFF: begin
        add_a = ng_q; add_b = og_q; add_sub = 1'b1; add_en = 1'b1;
      end
      snc_pkg::ST_SLOPE: begin
        add_a = nr_q; add_b = or_q; add_sub = 1'b1; add_en = 1'b1;
      end
      snc_pkg::ST_NEXT: begin
        add_a = ng_q; add_b = t0_q; add_sub = 1'b1; add_en = 1'b1;
      end
      snc_pkg::ST_K_SQ:   begin md_a = k_q;  md_b = k_q;   md_c = C_ONE; md_state = 1'b1; end
      snc_pkg::ST_K0_SQ:  begin md_a = C_K0; md_b = C_K0;  md_c = C_ONE; md_state = 1'b1; end
      snc_pkg::ST_HILL:   begin md_a = C_BK; md_b = t1_q;  md_c = t2_q;  md_state = 1'b1; end
      snc_pkg::ST_K_DIV:  begin md_a = k_q;  md_b = C_ONE; md_c = den_q; md_state = 1'b1; end
      snc_pkg::ST_Q:      begin md_a = k_q;  md_b = C_ONE; md_c = C_K1;  md_state = 1'b1; end
      snc_pkg::ST_Q2:     begin md_a = t1_q; md_b = t1_q;  md_c = C_ONE; md_state = 1'b1; end
      snc_pkg::ST_Q4:     begin md_a = t2_q; md_b = t2_q;  md_c = C_ONE; md_state = 1'b1; end
      snc_pkg::ST_Q5:     begin md_a = t2_q; md_b = t1_q;  md_c = C_ONE; md_state = 1'b1; end
      snc_pkg::ST_S_HILL: begin md_a = C_BS; md_b = C_ONE; md_c = t2_q;  md_state = 1'b1; end
      snc_pkg::ST_S_DIV:  begin md_a = s_val; md_b = C_ONE; md_c = den_q; md_state = 1'b1; end
      snc_pkg::ST_STEP:   begin md_a = nr_q; md_b = d_q;   md_c = den_q; md_state = 1'b1; end
      default: ;
    endcase
  end

  // finish: root, status
  always_comb begin
    fin        = 1'b0;
    fin_val    = ng_q;
    fin_status = snc_pkg::STAT_CONVERGED;
    unique case (state_q)
      snc_pkg::ST_DIFF:  fin = converged;
      snc_pkg::ST_SLOPE: begin fin = slope_zero; fin_status = snc_pkg::STAT_ZERO_DEN; end
      snc_pkg::ST_NEXT: begin
        fin = over_limit; fin_val = add_res; fin_status = snc_pkg::STAT_LIMIT;
      end
      default: ;
    endcase
    root_wide  = 64'(fin_val);
    root_hi    = root_wide > 64'sd2147483647;
    root_lo    = root_wide < -64'sd2147483648;
    fin_sat_in = sat_q || add_sat || root_hi || root_lo;
  end

  // datapath registers
  always_comb begin
    tol_d       = tol_q;
    limit_d     = limit_q;
    cnt_d       = cnt_q;
    k_d = k_q; ng_d = ng_q; og_d = og_q; nr_d = nr_q; or_d = or_q;
    t0_d = t0_q; t1_d = t1_q; t2_d = t2_q; den_d = den_q; d_d = d_q;
    op_d = op_q; sat_d = sat_q | add_sat; init_d = init_q; old_d = old_q;
    mwait_d     = mwait_q;
    out_valid_d = 1'b0;
    out_d       = out_q;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        snc_pkg::CFG_TOLERANCE:  tol_d   = cfg_data_i[snc_pkg::TOL_W-1:0];
        snc_pkg::CFG_ITER_LIMIT: limit_d = cfg_data_i[snc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end

    if (md_start) mwait_d = 1'b1;
    if (md_rsp.done) begin
      mwait_d = 1'b0;
      sat_d   = sat_d | md_rsp.sat;
    end

    unique case (state_q)
      snc_pkg::ST_IDLE: begin
        if (start) begin
          op_d   = req_i.op;
          k_d    = kin;
          ng_d   = g1in;
          og_d   = g2in;
          sat_d  = kin_sat | g1_sat | g2_sat;
          cnt_d  = '0;
          init_d = 1'b1;
          old_d  = 1'b0;
        end
      end
      snc_pkg::ST_DEN_A:    t0_d  = add_res;
      snc_pkg::ST_DEN_B:    den_d = add_res;
      snc_pkg::ST_HILL_DEN: t2_d  = add_res;
      snc_pkg::ST_K_BASE:   t0_d  = add_res;
      snc_pkg::ST_S_DEN:    t2_d  = add_res;
      snc_pkg::ST_K_SQ, snc_pkg::ST_K_DIV, snc_pkg::ST_Q, snc_pkg::ST_S_DIV:
        if (md_rsp.done) t1_d = md_res;
      snc_pkg::ST_K0_SQ, snc_pkg::ST_HILL, snc_pkg::ST_Q2, snc_pkg::ST_Q4, snc_pkg::ST_Q5:
        if (md_rsp.done) t2_d = md_res;
      snc_pkg::ST_S_HILL, snc_pkg::ST_STEP:
        if (md_rsp.done) t0_d = md_res;
      snc_pkg::ST_K_RATE, snc_pkg::ST_S_RATE: begin
        if (old_q) or_d = add_res;
        else nr_d = add_res;
        // after the newer guess, evaluate the older one once per item
        if (init_q && !old_q) old_d = 1'b1;
        else begin
          old_d  = 1'b0;
          init_d = 1'b0;
        end
      end
      snc_pkg::ST_DIFF:  d_d   = add_res;
      snc_pkg::ST_SLOPE: den_d = add_res;
      snc_pkg::ST_NEXT: begin
        og_d  = ng_q;
        or_d  = nr_q;
        ng_d  = add_res;
        cnt_d = cnt_inc;
      end
      default: ;
    endcase

    if (fin) begin
      out_valid_d      = 1'b1;
      out_d.root       = root_hi ? 32'sh7fffffff : (root_lo ? 32'sh80000000 : 32'(root_wide));
      out_d.iterations = (state_q == snc_pkg::ST_NEXT) ? cnt_inc : cnt_q;
      out_d.status     = (fin_status != snc_pkg::STAT_ZERO_DEN && fin_sat_in) ?
                         snc_pkg::STAT_SATURATED : fin_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= snc_pkg::ST_IDLE;
      tol_q       <= snc_pkg::TOL_RESET;
      limit_q     <= snc_pkg::LIMIT_RESET;
      mwait_q     <= 1'b0;
      out_valid_q <= 1'b0;
      init_q      <= 1'b0;
      old_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      tol_q       <= tol_d;
      limit_q     <= limit_d;
      mwait_q     <= mwait_d;
      out_valid_q <= out_valid_d;
      init_q      <= init_d;
      old_q       <= old_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    k_q   <= k_d;
    ng_q  <= ng_d;
    og_q  <= og_d;
    nr_q  <= nr_d;
    or_q  <= or_d;
    t0_q  <= t0_d;
    t1_q  <= t1_d;
    t2_q  <= t2_d;
    den_q <= den_d;
    d_q   <= d_d;
    op_q  <= op_d;
    sat_q <= sat_d;
    out_q <= out_d;
  end

  assign busy           = state_q != snc_pkg::ST_IDLE;
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

// ===== rtl/core/snc_muldiv.sv =====
module snc_muldiv #(
  parameter int unsigned VALUE_WIDTH = snc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [VALUE_WIDTH-1:0] a_i,
  input  logic signed [VALUE_WIDTH-1:0] b_i,
  input  logic signed [VALUE_WIDTH-1:0] c_i,
  output logic signed [VALUE_WIDTH-1:0] res_o,
  output snc_pkg::snc_md_rsp_t          rsp_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(W);
  localparam logic [CW-1:0] LAST = CW'(W - 1);
  localparam logic [W:0] LIM_POS = (W+1)'((W+1)'(1) << (W - 1)) - (W+1)'(1);
  localparam logic [W:0] LIM_NEG = (W+1)'((W+1)'(1) << (W - 1));

  snc_pkg::snc_ust_e ust_q, ust_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  hi_q, hi_d, lo_q, lo_d, ma_q, ma_d, mc_q, mc_d;
  logic          neg_q, neg_d, over_q, over_d;
  logic signed [W-1:0] res_q, res_d;
  logic          done_q, done_d, sat_q, sat_d;

  logic [W:0]   psum, r2, rdiff, qr, lim, mfin;
  logic         ge, rnd, big;
  logic [W-1:0] ma_in, mb_in, mc_in;

  assign ma_in = a_i[W-1] ? W'(-a_i) : W'(a_i);
  assign mb_in = b_i[W-1] ? W'(-b_i) : W'(b_i);
  assign mc_in = c_i[W-1] ? W'(-c_i) : W'(c_i);

  always_comb begin
    ust_d = ust_q;
    unique case (ust_q)
      snc_pkg::U_IDLE: if (start_i) ust_d = snc_pkg::U_MUL;
      snc_pkg::U_MUL:  if (cnt_q == LAST) ust_d = snc_pkg::U_DIV;
      snc_pkg::U_DIV:  if (cnt_q == LAST) ust_d = snc_pkg::U_FIN;
      snc_pkg::U_FIN:  ust_d = snc_pkg::U_IDLE;
      default:         ust_d = snc_pkg::U_IDLE;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    ma_d   = ma_q;
    mc_d   = mc_q;
    neg_d  = neg_q;
    over_d = over_q;
    res_d  = res_q;
    done_d = 1'b0;
    sat_d  = sat_q;
    psum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, ma_q} : '0);
    r2     = {hi_q, lo_q[W-1]};
    ge     = r2 >= {1'b0, mc_q};
    rdiff  = r2 - {1'b0, mc_q};
    rnd    = {hi_q, 1'b0} >= {1'b0, mc_q};
    qr     = {1'b0, lo_q} + (W+1)'(rnd);
    lim    = neg_q ? LIM_NEG : LIM_POS;
    big    = over_q || (qr > lim);
    mfin   = big ? lim : qr;
    unique case (ust_q)
      snc_pkg::U_IDLE: begin
        if (start_i) begin
          cnt_d  = '0;
          hi_d   = '0;
          lo_d   = mb_in;
          ma_d   = ma_in;
          mc_d   = mc_in;
          neg_d  = a_i[W-1] ^ b_i[W-1] ^ c_i[W-1];
        end
      end
      snc_pkg::U_MUL: begin
        // shift-add, one multiplier bit per cycle
        hi_d  = psum[W:1];
        lo_d  = {psum[0], lo_q[W-1:1]};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == LAST) begin
          cnt_d  = '0;
          // quotient would exceed W bits (covers a zero divisor too)
          over_d = psum[W:1] >= mc_q;
        end
      end
      snc_pkg::U_DIV: begin
        hi_d  = ge ? rdiff[W-1:0] : r2[W-1:0];
        lo_d  = {lo_q[W-2:0], ge};
        cnt_d = cnt_q + CW'(1);
      end
      snc_pkg::U_FIN: begin
        res_d  = W'(neg_q ? -mfin : mfin);
        sat_d  = big;
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ust_q  <= snc_pkg::U_IDLE;
      done_q <= 1'b0;
    end else begin
      ust_q  <= ust_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    ma_q   <= ma_d;
    mc_q   <= mc_d;
    neg_q  <= neg_d;
    over_q <= over_d;
    res_q  <= res_d;
    sat_q  <= sat_d;
  end

  assign res_o     = res_q;
  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam longint ONE  = 64'sd16777216;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  snc_pkg::snc_in_t req_i;
  logic result_valid_o;
  snc_pkg::snc_out_t result_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_index_i;
  logic [snc_pkg::CFG_W-1:0] cfg_data_i;

  secant_nullcline_solver u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_i(req_i),
    .result_valid_o(result_valid_o),
    .result_o(result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // predictor state
  logic [snc_pkg::TOL_W-1:0] tol_q;
  logic [snc_pkg::LIMIT_W-1:0] limit_q;
  bit clamped;
  snc_pkg::snc_out_t roots_pending[$];
  int unsigned fail_count;
  bit busy_n;
  bit cfg_ready_n;
  bit quiet;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #1_500_000_000;
    $display("Some tests failed");
    $finish;
  end

  // sample handshake inputs mid-cycle, away from the driving edge
  always @(negedge clk_i) begin
    busy_n <= busy;
    cfg_ready_n <= cfg_ready_o;
  end

  function automatic longint sat_clamp(longint x);
    if (x > VMAX) begin
      clamped = 1'b1;
      return VMAX;
    end
    if (x < VMIN) begin
      clamped = 1'b1;
      return VMIN;
    end
    return x;
  endfunction

  function automatic longint sat_add(longint a, longint b);
    return sat_clamp(a + b);
  endfunction

  function automatic longint sat_sub(longint a, longint b);
    return sat_clamp(a - b);
  endfunction

  function automatic logic [63:0] magn(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  // round(ma*mb/mc) to nearest, ties away from zero, then saturate
  function automatic longint scaled_quot(bit neg, logic [63:0] ma, logic [63:0] mb,
                                         logic [63:0] mc);
    logic [127:0] prod;
    logic [127:0] q;
    logic [127:0] r;
    logic [127:0] lim;
    if (mc == 0) begin
      clamped = 1'b1;
      return neg ? VMIN : VMAX;
    end
    prod = 128'(ma) * 128'(mb);
    q = prod / 128'(mc);
    r = prod % 128'(mc);
    if (r >= 128'(mc) - r) q = q + 1;
    lim = neg ? 128'(64'd2147483648) : 128'(64'd2147483647);
    if (q > lim) begin
      clamped = 1'b1;
      q = lim;
    end
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return scaled_quot((a < 0) != (b < 0), magn(a), magn(b), 64'(ONE));
  endfunction

  function automatic longint fx_div(longint a, longint b);
    return scaled_quot((a < 0) != (b < 0), magn(a), 64'(ONE), magn(b));
  endfunction

  function automatic longint fx_muldiv(longint a, longint b, longint c);
    return scaled_quot(((a < 0) != (b < 0)) != (c < 0), magn(a), magn(b), magn(c));
  endfunction

  function automatic longint milli(longint num);
    return ((num << 24) + 500) / 1000;
  endfunction

  function automatic longint growth_rate(bit op, longint s, longint k);
    longint den;
    longint k2;
    longint hill;
    longint q;
    longint q2;
    longint q5;
    den = sat_add(sat_add(ONE, k), s);
    if (op == 1'b0) begin
      k2 = fx_mul(k, k);
      hill = fx_muldiv(milli(70), k2, sat_add(fx_mul(milli(200), milli(200)), k2));
      return sat_sub(sat_add(milli(4), hill), fx_div(k, den));
    end
    q = fx_div(k, milli(222));
    q2 = fx_mul(q, q);
    q5 = fx_mul(fx_mul(q2, q2), q);
    return sat_sub(fx_div(milli(820), sat_add(ONE, q5)), fx_div(s, den));
  endfunction

  function automatic snc_pkg::snc_out_t solve_root(snc_pkg::snc_in_t it);
    longint k;
    longint s_new;
    longint s_old;
    longint f_new;
    longint f_old;
    longint d;
    longint den;
    longint nxt;
    int unsigned n;
    snc_pkg::snc_status_e st;
    snc_pkg::snc_out_t res;
    clamped = 1'b0;
    k = it.k_level;
    s_new = it.first_guess;
    s_old = it.second_guess;
    f_new = growth_rate(it.op, s_new, k);
    f_old = growth_rate(it.op, s_old, k);
    n = 0;
    forever begin
      d = sat_sub(s_new, s_old);
      if (magn(d) < 64'(tol_q)) begin
        st = snc_pkg::STAT_CONVERGED;
        break;
      end
      den = sat_sub(f_new, f_old);
      if (den == 0) begin
        st = snc_pkg::STAT_ZERO_DEN;
        break;
      end
      nxt = sat_sub(s_new, fx_muldiv(f_new, d, den));
      s_old = s_new;
      f_old = f_new;
      s_new = nxt;
      n++;
      if (n > limit_q) begin
        st = snc_pkg::STAT_LIMIT;
        break;
      end
      f_new = growth_rate(it.op, s_new, k);
    end
    if (clamped && st != snc_pkg::STAT_ZERO_DEN) st = snc_pkg::STAT_SATURATED;
    res.root = s_new[31:0];
    res.iterations = snc_pkg::ITER_W'(n);
    res.status = st;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (roots_pending.size() == 0) begin
        report_mismatch("unexpected result, root", result_o.root, 0);
      end else begin
        snc_pkg::snc_out_t want;
        want = roots_pending.pop_front();
        if (result_o.root !== want.root) report_mismatch("root", result_o.root, want.root);
        if (result_o.iterations !== want.iterations)
          report_mismatch("iterations", result_o.iterations, want.iterations);
        if (result_o.status !== want.status)
          report_mismatch("status", result_o.status, want.status);
      end
    end
  end

  // start stays high after a transfer unless a gap follows; stop_items drops it
  task automatic send_item(snc_pkg::snc_in_t it);
    int unsigned gap;
    req_i <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (busy_n);
    roots_pending.push_back(solve_root(it));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic stop_items();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (roots_pending.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(snc_pkg::snc_cfg_e idx, logic [snc_pkg::CFG_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_n);
    cfg_valid_i <= 1'b0;
    if (idx == snc_pkg::CFG_TOLERANCE) tol_q = data[snc_pkg::TOL_W-1:0];
    else limit_q = data[snc_pkg::LIMIT_W-1:0];
    @(posedge clk_i);
  endtask

  function automatic snc_pkg::snc_in_t make_item(bit op, longint k, longint s1, longint s2);
    snc_pkg::snc_in_t it;
    it.op = op;
    it.k_level = k[31:0];
    it.first_guess = s1[31:0];
    it.second_guess = s2[31:0];
    return it;
  endfunction

  function automatic snc_pkg::snc_in_t random_item();
    snc_pkg::snc_in_t it;
    if ($urandom_range(0, 4) == 0) begin
      it.op = $urandom_range(0, 1);
      it.k_level = $urandom();
      it.first_guess = $urandom();
      it.second_guess = $urandom();
    end else begin
      // well-posed: k in 0..3 and guesses in 0..4 (units of ONE), non-negative
      it.op = $urandom_range(0, 1);
      it.k_level = $urandom_range(0, 32'h0300_0000);
      it.first_guess = $urandom_range(0, 32'h0400_0000);
      it.second_guess = $urandom_range(0, 32'h0400_0000);
    end
    return it;
  endfunction

  task automatic test_directed();
    for (int op = 0; op < 2; op++) begin
      send_item(make_item(op, ONE / 2, ONE, ONE));
      send_item(make_item(op, ONE / 2, ONE, ONE / 4));
      send_item(make_item(op, 0, ONE, 2 * ONE));
      send_item(make_item(op, VMAX, VMAX, VMIN));
      send_item(make_item(op, VMIN, VMIN, VMAX));
      send_item(make_item(op, -ONE, 0, ONE));
      send_item(make_item(op, ONE, -ONE, 3 * ONE));
      send_item(make_item(op, 2 * ONE, 0, -1));
      send_item(make_item(op, -1, VMAX, 0));
      send_item(make_item(op, ONE / 5, ONE / 10, ONE / 3));
    end
    stop_items();
    drain();
  endtask

  task automatic test_config();
    write_reg(snc_pkg::CFG_TOLERANCE, 0);
    write_reg(snc_pkg::CFG_ITER_LIMIT, 63);
    send_item(make_item(1'b1, ONE / 2, ONE, ONE / 4));
    send_item(make_item(1'b0, ONE / 3, 2 * ONE, 0));
    stop_items();
    drain();
    write_reg(snc_pkg::CFG_TOLERANCE, 16777216);
    write_reg(snc_pkg::CFG_ITER_LIMIT, 1);
    send_item(make_item(1'b1, ONE / 2, 3 * ONE, 0));
    send_item(make_item(1'b0, ONE / 2, ONE / 2, 0));
    stop_items();
    drain();
    write_reg(snc_pkg::CFG_TOLERANCE, 0);
    write_reg(snc_pkg::CFG_ITER_LIMIT, 0);
    send_item(make_item(1'b1, ONE / 2, ONE, ONE / 4));
    send_item(make_item(1'b0, ONE, ONE, 0));
    stop_items();
    drain();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(snc_pkg::CFG_TOLERANCE,
                ($urandom_range(0, 1) == 1) ? $urandom_range(0, 16777216)
                                            : $urandom_range(0, 64));
      write_reg(snc_pkg::CFG_ITER_LIMIT,
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                            : $urandom_range(1, 12));
      quiet = (phase == 3);
      for (int i = 0; i < 100; i++) send_item(random_item());
      stop_items();
      drain();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = snc_pkg::CFG_TOLERANCE;
    cfg_data_i = '0;
    tol_q = snc_pkg::TOL_RESET;
    limit_q = snc_pkg::LIMIT_RESET;
    fail_count = 0;
    quiet = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config();
    test_random();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && roots_pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/snc_pkg.sv
rtl/core/snc_muldiv.sv
rtl/core/secant_nullcline_solver.sv
tb/sv/testbench.sv
